>>> design/hng_pkg.sv
// ----------------------------------------------------------------------------
// Heightmap normal generator package
// Shared constants, payload structs, state and command types.
// ----------------------------------------------------------------------------
package hng_pkg;

  localparam int MAX_GRID_WIDTH  = 256;
  localparam int MAX_GRID_HEIGHT = 4096;
  localparam int MAX_BORDER      = 8;
  localparam int LINE_DEPTH      = MAX_GRID_WIDTH + 2 * MAX_BORDER;
  localparam int LINE_AW         = $clog2(LINE_DEPTH);

  localparam int DIV_NUM_W  = 40;
  localparam int DIV_DEN_W  = 25;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);
  localparam int SQ_W       = 48;
  localparam int ROOT_W     = 25;
  localparam int SQRT_STEPS = 24;
  localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

  localparam logic [22:0] SLOPE_LIMIT = 23'h7F_FFFF;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_FLUSH  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_GRID_WIDTH   = 2'd0,
    CFG_GRID_HEIGHT  = 2'd1,
    CFG_CELL_SIZE    = 2'd2,
    CFG_BORDER_WIDTH = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] height_sample;
  } in_item_t;

  typedef struct packed {
    logic        [7:0]  vertex_col;
    logic        [11:0] vertex_row;
    logic signed [15:0] vertex_height;
    logic signed [15:0] normal_x;
    logic        [14:0] normal_y;
    logic signed [15:0] normal_z;
    logic               last_vertex;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_UPD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SQX,
    ST_SQZ,
    ST_SUM,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_FINISH
  } ctrl_state_e;

  typedef enum logic [2:0] {
    DIV_SX,
    DIV_SZ,
    DIV_NY,
    DIV_NX,
    DIV_NZ
  } div_op_e;

  typedef enum logic [1:0] {
    RD_P0,
    RD_P1,
    RD_P2
  } rd_phase_e;

  typedef struct packed {
    logic      capture;
    rd_phase_e rd_phase;
    logic      lat_a;
    logic      lat_b;
    logic      update;
    logic      div_start;
    logic      div_take;
    div_op_e   div_op;
    logic      sq_x;
    logic      sq_z;
    logic      sq_sum;
    logic      sqrt_start;
    logic      sqrt_take;
    logic      out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic emit;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } dp_status_t;

endpackage

>>> design/hng_div.sv
// ----------------------------------------------------------------------------
// Heightmap normal generator divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hng_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [hng_pkg::DIV_NUM_W-1:0]  num_i,
  input  logic [hng_pkg::DIV_DEN_W-1:0]  den_i,
  output logic                           done_o,
  output logic [hng_pkg::DIV_NUM_W-1:0]  quo_o
);

  logic                          busy_q, done_q;
  logic [hng_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [hng_pkg::DIV_NUM_W-1:0] num_q;
  logic [hng_pkg::DIV_DEN_W-1:0] den_q, rem_q;
  logic [hng_pkg::DIV_DEN_W:0]   trial, rem_d;
  logic                          ge;

  always_comb begin
    trial = {rem_q, num_q[hng_pkg::DIV_NUM_W-1]};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? (trial - {1'b0, den_q}) : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == hng_pkg::DIV_CNT_W'(hng_pkg::DIV_NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[hng_pkg::DIV_NUM_W-2:0], ge};
      rem_q <= rem_d[hng_pkg::DIV_DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

>>> design/hng_isqrt.sv
// ----------------------------------------------------------------------------
// Heightmap normal generator square root
// Bit-pair integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module hng_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [hng_pkg::SQ_W-1:0]    radicand_i,
  output logic                        done_o,
  output logic [hng_pkg::ROOT_W-1:0]  root_o
);

  logic                           busy_q, done_q;
  logic [hng_pkg::SQRT_CNT_W-1:0] k_q;
  logic [hng_pkg::SQ_W-1:0]       v_q, res_q, bit_w;
  logic [hng_pkg::SQ_W:0]         trial;
  logic                           ge;

  always_comb begin
    bit_w = hng_pkg::SQ_W'(1) << {k_q, 1'b0};
    trial = {1'b0, res_q} + {1'b0, bit_w};
    ge    = {1'b0, v_q} >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        k_q    <= hng_pkg::SQRT_CNT_W'(hng_pkg::SQRT_STEPS - 1);
      end else if (busy_q) begin
        if (k_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          k_q <= k_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= radicand_i;
      res_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        v_q   <= v_q - trial[hng_pkg::SQ_W-1:0];
        res_q <= (res_q >> 1) + bit_w;
      end else begin
        res_q <= res_q >> 1;
      end
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[hng_pkg::ROOT_W-1:0];

endmodule

>>> design/hng_ctrl.sv
// ----------------------------------------------------------------------------
// Heightmap normal generator controller
// Sequences line reads, counter update and the normal arithmetic per beat.
// ----------------------------------------------------------------------------
module hng_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hng_pkg::dp_status_t status_i,
  output hng_pkg::ctrl_cmd_t  cmd_o
);

  hng_pkg::ctrl_state_e state_q, state_d;
  hng_pkg::div_op_e     op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hng_pkg::ST_IDLE;
      op_q    <= hng_pkg::DIV_SX;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    cmd_o.rd_phase = hng_pkg::RD_P0;
    cmd_o.div_op   = op_q;
    unique case (state_q)
      hng_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = hng_pkg::ST_RD0;
        end
      end
      hng_pkg::ST_RD0: begin
        cmd_o.rd_phase = hng_pkg::RD_P0;
        state_d = hng_pkg::ST_RD1;
      end
      hng_pkg::ST_RD1: begin
        cmd_o.rd_phase = hng_pkg::RD_P1;
        cmd_o.lat_a = 1'b1;
        state_d = hng_pkg::ST_RD2;
      end
      hng_pkg::ST_RD2: begin
        cmd_o.rd_phase = hng_pkg::RD_P2;
        cmd_o.lat_b = 1'b1;
        state_d = hng_pkg::ST_UPD;
      end
      hng_pkg::ST_UPD: begin
        cmd_o.update = 1'b1;
        if (status_i.emit) begin
          op_d = hng_pkg::DIV_SX;
          state_d = hng_pkg::ST_DIV_GO;
        end else begin
          state_d = hng_pkg::ST_IDLE;
        end
      end
      hng_pkg::ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d = hng_pkg::ST_DIV_WAIT;
      end
      hng_pkg::ST_DIV_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.div_take = 1'b1;
          case (op_q)
            hng_pkg::DIV_SX: begin
              op_d = hng_pkg::DIV_SZ;
              state_d = hng_pkg::ST_DIV_GO;
            end
            hng_pkg::DIV_SZ: state_d = hng_pkg::ST_SQX;
            hng_pkg::DIV_NY: begin
              op_d = hng_pkg::DIV_NX;
              state_d = hng_pkg::ST_DIV_GO;
            end
            hng_pkg::DIV_NX: begin
              op_d = hng_pkg::DIV_NZ;
              state_d = hng_pkg::ST_DIV_GO;
            end
            hng_pkg::DIV_NZ: state_d = hng_pkg::ST_FINISH;
            default: state_d = hng_pkg::ST_IDLE;
          endcase
        end
      end
      hng_pkg::ST_SQX: begin
        cmd_o.sq_x = 1'b1;
        state_d = hng_pkg::ST_SQZ;
      end
      hng_pkg::ST_SQZ: begin
        cmd_o.sq_z = 1'b1;
        state_d = hng_pkg::ST_SUM;
      end
      hng_pkg::ST_SUM: begin
        cmd_o.sq_sum = 1'b1;
        state_d = hng_pkg::ST_SQRT_GO;
      end
      hng_pkg::ST_SQRT_GO: begin
        cmd_o.sqrt_start = 1'b1;
        state_d = hng_pkg::ST_SQRT_WAIT;
      end
      hng_pkg::ST_SQRT_WAIT: begin
        if (status_i.sqrt_done) begin
          cmd_o.sqrt_take = 1'b1;
          op_d = hng_pkg::DIV_NY;
          state_d = hng_pkg::ST_DIV_GO;
        end
      end
      hng_pkg::ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = hng_pkg::ST_IDLE;
        end
      end
      default: state_d = hng_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> design/hng_datapath.sv
// ----------------------------------------------------------------------------
// Heightmap normal generator datapath
// Configuration, frame counters, line stores, slope and normal arithmetic.
// ----------------------------------------------------------------------------
module hng_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hng_pkg::ctrl_cmd_t   cmd_i,
  output hng_pkg::dp_status_t  status_o,
  input  hng_pkg::in_item_t    in_data_i,
  input  logic                 cfg_valid_i,
  input  hng_pkg::cfg_idx_e    cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output hng_pkg::out_item_t   out_data_o
);

  function automatic logic [hng_pkg::LINE_AW-1:0] clamp_addr(input logic [9:0] a);
    return (a < 10'(hng_pkg::LINE_DEPTH)) ? a[hng_pkg::LINE_AW-1:0] : '0;
  endfunction

  function automatic logic [15:0] neg_comp(input logic [hng_pkg::DIV_NUM_W-1:0] q,
                                           input logic neg);
    logic [15:0] r;
    if (!neg) begin
      r = (q > 40'd32768) ? 16'h8000 : (16'h0000 - q[15:0]);
    end else begin
      r = (q > 40'd32767) ? 16'h7FFF : q[15:0];
    end
    return r;
  endfunction

  // Configuration and frame counters.
  logic [8:0]  gw_q, flush_q, col_q;
  logic [12:0] gh_q, row_q;
  logic [15:0] cell_q;
  logic [3:0]  bw_q;

  logic [8:0]  gw, pw;
  logic [12:0] gh, ph, pr;
  logic [3:0]  bw;
  logic [15:0] cell_eff;
  logic        waiting;

  always_comb begin
    gw = (gw_q < 9'd2) ? 9'd2 :
         (gw_q > 9'(hng_pkg::MAX_GRID_WIDTH)) ? 9'(hng_pkg::MAX_GRID_WIDTH) : gw_q;
    gh = (gh_q < 13'd2) ? 13'd2 :
         (gh_q > 13'(hng_pkg::MAX_GRID_HEIGHT)) ? 13'(hng_pkg::MAX_GRID_HEIGHT) : gh_q;
    bw = (bw_q > 4'(hng_pkg::MAX_BORDER)) ? 4'(hng_pkg::MAX_BORDER) : bw_q;
    cell_eff = (cell_q == '0) ? 16'd1 : cell_q;
    pw = gw + {4'b0, bw, 1'b0};
    ph = gh + {8'b0, bw, 1'b0};
    waiting = row_q >= ph;
    pr = row_q - 13'd1;
  end

  // Captured item and line store reads.
  logic               op_q;
  logic signed [15:0] sample_q;
  logic [15:0]        mid_mem [hng_pkg::LINE_DEPTH];
  logic [15:0]        up_mem  [hng_pkg::LINE_DEPTH];
  logic [15:0]        mid_rd_q, up_rd_q;
  logic signed [15:0] h0_q, u0_q, h1_q, u1_q;
  logic [8:0]         pos;
  logic [9:0]         pos_p1, pos_m1;
  logic [hng_pkg::LINE_AW-1:0] mid_ra, up_ra;
  logic               line_we;

  always_comb begin
    pos    = (op_q == hng_pkg::OP_FLUSH) ? flush_q : col_q;
    pos_p1 = {1'b0, pos} + 10'd1;
    pos_m1 = {1'b0, pos} - 10'd1;
    mid_ra = clamp_addr({1'b0, pos});
    up_ra  = clamp_addr({1'b0, pos});
    case (cmd_i.rd_phase)
      hng_pkg::RD_P1: begin
        mid_ra = clamp_addr(pos_p1);
        up_ra  = clamp_addr(pos_m1);
      end
      hng_pkg::RD_P2: mid_ra = clamp_addr(pos_m1);
      default: ;
    endcase
  end

  assign line_we = cmd_i.update && (op_q == hng_pkg::OP_SAMPLE) && !waiting;

  always_ff @(posedge clk_i) begin
    if (line_we) begin
      mid_mem[col_q[hng_pkg::LINE_AW-1:0]] <= sample_q;
      up_mem[col_q[hng_pkg::LINE_AW-1:0]]  <= h0_q;
    end
    mid_rd_q <= mid_mem[mid_ra];
    up_rd_q  <= up_mem[up_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= in_data_i.opcode;
      sample_q <= in_data_i.height_sample;
    end
    if (cmd_i.lat_a) begin
      h0_q <= mid_rd_q;
      u0_q <= up_rd_q;
    end
    if (cmd_i.lat_b) begin
      h1_q <= mid_rd_q;
      u1_q <= up_rd_q;
    end
  end

  // Neighbor selection for the vertex that this beat completes.
  logic signed [15:0] hc, hl, hr, hp, hn;
  logic               bx, bz, emit;
  logic [8:0]         vx;
  logic [12:0]        vz;
  logic signed [16:0] dx, dz;

  always_comb begin
    hc = h0_q;
    hl = h0_q;
    hr = h0_q;
    hp = h0_q;
    hn = sample_q;
    bx = 1'b0;
    bz = 1'b0;
    vx = col_q;
    vz = pr;
    emit = 1'b0;
    if (op_q == hng_pkg::OP_FLUSH) begin
      vx = flush_q;
      vz = gh - 13'd1;
      hn = h0_q;
      hp = u0_q;
      if (flush_q != '0) hl = mid_rd_q;
      if (flush_q < gw - 9'd1) hr = h1_q;
      bx = (flush_q != '0) && (flush_q < gw - 9'd1);
      emit = waiting && (bw == '0) && (flush_q < gw);
    end else if (bw != '0) begin
      hl = (col_q != '0) ? u1_q : h0_q;
      hr = h1_q;
      hp = u0_q;
      bx = 1'b1;
      bz = 1'b1;
      vx = col_q - {5'b0, bw};
      vz = pr - {9'b0, bw};
      emit = !waiting && (row_q != '0) && (col_q >= {5'b0, bw})
             && ({1'b0, col_q} < ({1'b0, gw} + {6'b0, bw}))
             && (pr >= {9'b0, bw})
             && ({1'b0, pr} < ({1'b0, gh} + {10'b0, bw}));
    end else begin
      if (col_q != '0) hl = u1_q;
      if (col_q < gw - 9'd1) hr = h1_q;
      if (pr != '0) hp = u0_q;
      bx = (col_q != '0) && (col_q < gw - 9'd1);
      bz = (pr != '0);
      emit = !waiting && (row_q != '0) && (col_q < gw) && (pr < gh);
    end
    dx = {hr[15], hr} - {hl[15], hl};
    dz = {hn[15], hn} - {hp[15], hp};
  end

  // Counters and configuration registers.
  logic [9:0]  col_inc, flush_inc;
  logic [12:0] row_inc;

  always_comb begin
    col_inc   = {1'b0, col_q} + 10'd1;
    flush_inc = {1'b0, flush_q} + 10'd1;
    row_inc   = row_q + 13'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q    <= 9'd2;
      gh_q    <= 13'd2;
      cell_q  <= 16'd256;
      bw_q    <= '0;
      col_q   <= '0;
      row_q   <= '0;
      flush_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hng_pkg::CFG_GRID_WIDTH:   gw_q   <= cfg_data_i[8:0];
        hng_pkg::CFG_GRID_HEIGHT:  gh_q   <= cfg_data_i[12:0];
        hng_pkg::CFG_CELL_SIZE:    cell_q <= cfg_data_i;
        hng_pkg::CFG_BORDER_WIDTH: bw_q   <= cfg_data_i[3:0];
        default: ;
      endcase
      col_q   <= '0;
      row_q   <= '0;
      flush_q <= '0;
    end else if (cmd_i.update) begin
      if (op_q == hng_pkg::OP_FLUSH) begin
        if (waiting) begin
          if ((flush_inc >= {1'b0, gw}) || (bw != '0)) begin
            col_q   <= '0;
            row_q   <= '0;
            flush_q <= '0;
          end else begin
            flush_q <= flush_inc[8:0];
          end
        end
      end else if (!waiting) begin
        if (col_inc >= {1'b0, pw}) begin
          col_q <= '0;
          row_q <= ((row_inc >= ph) && (bw != '0)) ? '0 : row_inc;
        end else begin
          col_q <= col_inc[8:0];
        end
      end
    end
  end

  // Vertex operands.
  logic [8:0]         vx_q;
  logic [12:0]        vz_q;
  logic signed [15:0] hc_q;
  logic               dx_neg_q, dz_neg_q, bx_q, bz_q, last_q;
  logic [15:0]        dx_mag_q, dz_mag_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      vx_q     <= vx;
      vz_q     <= vz;
      hc_q     <= hc;
      bx_q     <= bx;
      bz_q     <= bz;
      last_q   <= (vx == gw - 9'd1) && (vz == gh - 13'd1);
      dx_neg_q <= dx[16];
      dz_neg_q <= dz[16];
      dx_mag_q <= dx[16] ? 16'(-dx) : dx[15:0];
      dz_mag_q <= dz[16] ? 16'(-dz) : dz[15:0];
    end
  end

  // Shared divider and square root.
  logic [hng_pkg::DIV_NUM_W-1:0] div_num, quo;
  logic [hng_pkg::DIV_DEN_W-1:0] div_den;
  logic                          div_done, sqrt_done;
  logic [16:0]                   den_x, den_z;
  logic [22:0]                   sx_mag_q, sz_mag_q, slope_sat;
  logic                          sx_neg_q, sz_neg_q;
  logic [hng_pkg::ROOT_W-1:0]    len_q, root;
  logic [hng_pkg::SQ_W-1:0]      acc_q;
  logic [45:0]                   sq_q, sq_a, prod;
  logic [14:0]                   ny_q;
  logic [15:0]                   nx_q, nz_q;

  always_comb begin
    den_x = bx_q ? {cell_eff, 1'b0} : {1'b0, cell_eff};
    den_z = bz_q ? {cell_eff, 1'b0} : {1'b0, cell_eff};
    div_num = '0;
    div_den = 25'd1;
    case (cmd_i.div_op)
      hng_pkg::DIV_SX: begin
        div_num = 40'({dx_mag_q, 16'h0000}) + 40'(den_x[16:1]);
        div_den = 25'(den_x);
      end
      hng_pkg::DIV_SZ: begin
        div_num = 40'({dz_mag_q, 16'h0000}) + 40'(den_z[16:1]);
        div_den = 25'(den_z);
      end
      hng_pkg::DIV_NY: begin
        div_num = 40'(32'h8000_0000) + 40'(len_q[24:1]);
        div_den = len_q;
      end
      hng_pkg::DIV_NX: begin
        div_num = 40'({sx_mag_q, 15'h0000}) + 40'(len_q[24:1]);
        div_den = len_q;
      end
      hng_pkg::DIV_NZ: begin
        div_num = 40'({sz_mag_q, 15'h0000}) + 40'(len_q[24:1]);
        div_den = len_q;
      end
      default: ;
    endcase
    slope_sat = (quo > 40'(hng_pkg::SLOPE_LIMIT)) ? hng_pkg::SLOPE_LIMIT : quo[22:0];
    sq_a = cmd_i.sq_z ? {23'b0, sz_mag_q} : {23'b0, sx_mag_q};
    prod = sq_a * sq_a;
  end

  hng_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  hng_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i (acc_q),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_take) begin
      case (cmd_i.div_op)
        hng_pkg::DIV_SX: begin
          sx_mag_q <= slope_sat;
          sx_neg_q <= dx_neg_q;
        end
        hng_pkg::DIV_SZ: begin
          sz_mag_q <= slope_sat;
          sz_neg_q <= dz_neg_q;
        end
        hng_pkg::DIV_NY: ny_q <= (quo > 40'd32767) ? 15'h7FFF : quo[14:0];
        hng_pkg::DIV_NX: nx_q <= neg_comp(quo, sx_neg_q);
        hng_pkg::DIV_NZ: nz_q <= neg_comp(quo, sz_neg_q);
        default: ;
      endcase
    end
    if (cmd_i.sq_x) begin
      sq_q <= prod;
    end
    if (cmd_i.sq_z) begin
      sq_q  <= prod;
      acc_q <= {2'b00, sq_q} + 48'h1_0000_0000;
    end
    if (cmd_i.sq_sum) begin
      acc_q <= acc_q + {2'b00, sq_q};
    end
    if (cmd_i.sqrt_take) begin
      len_q <= root;
    end
  end

  // Output register.
  logic               out_valid_q;
  hng_pkg::out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.vertex_col    <= vx_q[7:0];
      out_q.vertex_row    <= vz_q[11:0];
      out_q.vertex_height <= hc_q;
      out_q.normal_x      <= nx_q;
      out_q.normal_y      <= ny_q;
      out_q.normal_z      <= nz_q;
      out_q.last_vertex   <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    status_o.emit      = emit;
    status_o.div_done  = div_done;
    status_o.sqrt_done = sqrt_done;
    status_o.out_free  = !out_valid_q || !out_stall_i;
  end

endmodule

>>> design/heightmap_normal_generator.sv
// ----------------------------------------------------------------------------
// Heightmap normal generator
// Streams padded heightmap samples and emits central-difference unit normals.
// ----------------------------------------------------------------------------
// A beat that completes no vertex passes through the read and update states before
// the next is accepted. A beat that completes a vertex then runs five divisions and
// a square root in turn, each with its own start and handoff states.
// The result sits in an output register, so the next beat is taken while it waits.
// Reset restores the default configuration and clears the frame counters.
// Line store contents stay undefined until written.
module heightmap_normal_generator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  hng_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hng_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  hng_pkg::cfg_idx_e  cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  hng_pkg::ctrl_cmd_t  cmd;
  hng_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  hng_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hng_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Heightmap normal generator testbench
// Streams padded heightmap frames under several grid settings, with random
// idling, stalls and one long output hold-off. Every vertex is checked field
// by field against normals computed here in fixed point.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 300;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  hng_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  hng_pkg::out_item_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  hng_pkg::cfg_idx_e  cfg_index;
  logic [15:0]        cfg_data;

  heightmap_normal_generator i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the grid settings and the line stores.
  int unsigned reg_width, reg_height, reg_cell, reg_border;
  logic [15:0] upper_row [hng_pkg::LINE_DEPTH];
  logic [15:0] middle_row [hng_pkg::LINE_DEPTH];
  int unsigned col_cnt, row_cnt, flush_cnt;

  hng_pkg::out_item_t pending_vertices[$];
  int        mismatches;
  int        vertices_seen;
  int        beats_sent;
  int        idle_cycles;
  bit        quiet_out;

  function automatic int unsigned used_width();
    return reg_width < 2 ? 2 : (reg_width > hng_pkg::MAX_GRID_WIDTH ?
                                hng_pkg::MAX_GRID_WIDTH : reg_width);
  endfunction

  function automatic int unsigned used_height();
    return reg_height < 2 ? 2 : (reg_height > hng_pkg::MAX_GRID_HEIGHT ?
                                 hng_pkg::MAX_GRID_HEIGHT : reg_height);
  endfunction

  function automatic int unsigned used_border();
    return reg_border > hng_pkg::MAX_BORDER ? hng_pkg::MAX_BORDER : reg_border;
  endfunction

  function automatic int signed line_rd(logic [15:0] v);
    return int'($signed(v));
  endfunction

  function automatic longint slope_q816(int signed diff, longint unsigned denom);
    longint unsigned mag, q;
    mag = diff < 0 ? longint'(-diff) : longint'(diff);
    q = (mag * 65536 + denom / 2) / denom;
    if (q > hng_pkg::SLOPE_LIMIT) q = hng_pkg::SLOPE_LIMIT;
    return diff < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] unit_component(longint s, longint unsigned len);
    longint unsigned mag, q;
    mag = s < 0 ? longint'(-s) : longint'(s);
    q = (mag * 32768 + len / 2) / len;
    if (s > 0) begin
      if (q > 32768) q = 32768;
      return 16'(-longint'(q));
    end
    if (q > 32767) q = 32767;
    return 16'(q);
  endfunction

  function automatic hng_pkg::out_item_t compute_normal(int unsigned x, int unsigned z,
      int signed hc, int signed hl, int signed hr, bit both_x,
      int signed hp, int signed hn, bit both_z);
    hng_pkg::out_item_t v;
    longint unsigned cell_eff, len, ny;
    longint sx, sz;
    cell_eff = reg_cell == 0 ? 1 : reg_cell;
    sx = slope_q816(hr - hl, both_x ? 2 * cell_eff : cell_eff);
    sz = slope_q816(hn - hp, both_z ? 2 * cell_eff : cell_eff);
    len = int_sqrt(longint'(sx * sx) + longint'(sz * sz) + (64'd1 << 32));
    ny = ((64'd1 << 31) + len / 2) / len;
    if (ny > 32767) ny = 32767;
    v.vertex_col    = 8'(x);
    v.vertex_row    = 12'(z);
    v.vertex_height = 16'(hc);
    v.normal_x      = unit_component(sx, len);
    v.normal_y      = 15'(ny);
    v.normal_z      = unit_component(sz, len);
    v.last_vertex   = (x == used_width() - 1 && z == used_height() - 1);
    return v;
  endfunction

  function automatic void restart_frame();
    col_cnt = 0;
    row_cnt = 0;
    flush_cnt = 0;
  endfunction

  function automatic bit awaiting_flush();
    return row_cnt >= used_height() + 2 * used_border();
  endfunction

  // Advances the shadow state by one beat; returns 1 when a vertex follows.
  function automatic bit step_grid(hng_pkg::in_item_t item, output hng_pkg::out_item_t v);
    int unsigned gw, gh, b, pw, ph, c, r, x, pr;
    int signed hc, hl, hr, up, right, left, sample;
    bit emit;
    gw = used_width();
    gh = used_height();
    b = used_border();
    pw = gw + 2 * b;
    ph = gh + 2 * b;
    emit = 0;
    v = '0;
    if (item.opcode == hng_pkg::OP_FLUSH) begin
      if (!awaiting_flush()) return 0;
      x = flush_cnt;
      if (b == 0 && x < gw) begin
        hc = line_rd(middle_row[x]);
        hl = x > 0 ? line_rd(middle_row[x - 1]) : hc;
        hr = x < gw - 1 ? line_rd(middle_row[x + 1]) : hc;
        v = compute_normal(x, gh - 1, hc, hl, hr, x > 0 && x < gw - 1,
                           line_rd(upper_row[x]), hc, 0);
        emit = 1;
      end
      flush_cnt++;
      if (flush_cnt >= gw || b != 0) restart_frame();
      return emit;
    end
    if (awaiting_flush()) return 0;
    c = col_cnt;
    r = row_cnt;
    sample = int'(item.height_sample);
    hc = line_rd(middle_row[c]);
    up = line_rd(upper_row[c]);
    right = c + 1 < hng_pkg::LINE_DEPTH ? line_rd(middle_row[c + 1]) : 0;
    left = c > 0 ? line_rd(upper_row[c - 1]) : hc;
    if (r >= 1) begin
      pr = r - 1;
      if (b > 0) begin
        if (c >= b && c < b + gw && pr >= b && pr < b + gh) begin
          v = compute_normal(c - b, pr - b, hc, left, right, 1, up, sample, 1);
          emit = 1;
        end
      end else if (c < gw && pr < gh) begin
        v = compute_normal(c, pr, hc, c > 0 ? left : hc, c < gw - 1 ? right : hc,
                           c > 0 && c < gw - 1, pr > 0 ? up : hc, sample, pr > 0);
        emit = 1;
      end
    end
    upper_row[c] = middle_row[c];
    middle_row[c] = item.height_sample;
    c++;
    if (c >= pw) begin
      c = 0;
      r++;
      if (r >= ph && b != 0) r = 0;
    end
    col_cnt = c;
    row_cnt = r;
    return emit;
  endfunction

  task automatic write_register(hng_pkg::cfg_idx_e idx, int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 16'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      hng_pkg::CFG_GRID_WIDTH:   reg_width  = value & 16'h01FF;
      hng_pkg::CFG_GRID_HEIGHT:  reg_height = value & 16'h1FFF;
      hng_pkg::CFG_CELL_SIZE:    reg_cell   = value & 16'hFFFF;
      hng_pkg::CFG_BORDER_WIDTH: reg_border = value & 16'h000F;
      default: ;
    endcase
    restart_frame();
  endtask

  task automatic set_grid(int unsigned w, int unsigned h, int unsigned cell_sz,
                          int unsigned b);
    write_register(hng_pkg::CFG_GRID_WIDTH, w);
    write_register(hng_pkg::CFG_GRID_HEIGHT, h);
    write_register(hng_pkg::CFG_CELL_SIZE, cell_sz);
    write_register(hng_pkg::CFG_BORDER_WIDTH, b);
    cfg_valid <= 1'b0;
  endtask

  // Sends one beat; a fixed expectation overrides the computed one.
  task automatic send_beat(hng_pkg::in_item_t item, bit idle_ok, bit fixed,
                           hng_pkg::out_item_t fixed_v);
    hng_pkg::out_item_t v;
    while (idle_ok && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    if (step_grid(item, v)) pending_vertices = {pending_vertices, fixed ? fixed_v : v};
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(int unsigned count);
    hng_pkg::in_item_t item;
    for (int i = 0; i < count; i++) begin
      if (awaiting_flush())
        item.opcode = $urandom_range(0, 9) < 9 ? hng_pkg::OP_FLUSH : hng_pkg::OP_SAMPLE;
      else
        item.opcode = $urandom_range(0, 19) == 0 ? hng_pkg::OP_FLUSH : hng_pkg::OP_SAMPLE;
      if ($urandom_range(0, 3) == 0) item.height_sample = 16'($urandom);
      else item.height_sample = 16'($signed($urandom_range(0, 128)) - 64);
      send_beat(item, !(beats_sent >= 500 && beats_sent < 800), 0, '0);
    end
    wait_drained();
  endtask

  typedef struct {
    hng_pkg::opcode_e op;
    logic [15:0]      height;
    bit               fixed;
    logic [7:0]       col;
    logic [11:0]      row;
    logic             last;
  } directed_row_t;

  directed_row_t directed_rows[] = '{
    '{hng_pkg::OP_FLUSH,  16'h0000, 0, 8'd0, 12'd0, 1'b0},
    '{hng_pkg::OP_SAMPLE, 16'h0000, 0, 8'd0, 12'd0, 1'b0},
    '{hng_pkg::OP_SAMPLE, 16'h0000, 0, 8'd0, 12'd0, 1'b0},
    '{hng_pkg::OP_SAMPLE, 16'h0000, 1, 8'd0, 12'd0, 1'b0},
    '{hng_pkg::OP_SAMPLE, 16'h0000, 1, 8'd1, 12'd0, 1'b0},
    '{hng_pkg::OP_SAMPLE, 16'h7FFF, 0, 8'd0, 12'd0, 1'b0},
    '{hng_pkg::OP_FLUSH,  16'h0000, 1, 8'd0, 12'd1, 1'b0},
    '{hng_pkg::OP_FLUSH,  16'h0000, 1, 8'd1, 12'd1, 1'b1},
    '{hng_pkg::OP_SAMPLE, 16'h8000, 0, 8'd0, 12'd0, 1'b0},
    '{hng_pkg::OP_SAMPLE, 16'h7FFF, 0, 8'd0, 12'd0, 1'b0},
    '{hng_pkg::OP_SAMPLE, 16'h7FFF, 0, 8'd0, 12'd0, 1'b0},
    '{hng_pkg::OP_SAMPLE, 16'h8000, 0, 8'd0, 12'd0, 1'b0},
    '{hng_pkg::OP_FLUSH,  16'hFFFF, 0, 8'd0, 12'd0, 1'b0},
    '{hng_pkg::OP_FLUSH,  16'h0000, 0, 8'd0, 12'd0, 1'b0}
  };

  task automatic compare_field(string name, longint expected, longint actual);
    if (expected != actual) begin
      $error("%s: expected %0d, got %0d", name, expected, actual);
      mismatches++;
    end
  endtask

  // Vertex receiver with random stalls and one long hold-off.
  initial begin
    hng_pkg::out_item_t exp_v;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (vertices_seen == 200) begin
        out_stall <= 1'b1;
        repeat (2000) @(posedge clk);
        vertices_seen++;
      end
      quiet_out = vertices_seen >= 300 && vertices_seen < 500;
      out_stall <= !quiet_out && $urandom_range(0, 99) < 12;
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (vertices_seen != 200) vertices_seen++;
        if (pending_vertices.size() == 0) begin
          $error("vertex (%0d,%0d) arrived with none expected",
                 out_data.vertex_col, out_data.vertex_row);
          mismatches++;
        end else begin
          exp_v = pending_vertices.pop_front();
          compare_field("vertex_col", exp_v.vertex_col, out_data.vertex_col);
          compare_field("vertex_row", exp_v.vertex_row, out_data.vertex_row);
          compare_field("vertex_height", exp_v.vertex_height, out_data.vertex_height);
          compare_field("normal_x", exp_v.normal_x, out_data.normal_x);
          compare_field("normal_y", exp_v.normal_y, out_data.normal_y);
          compare_field("normal_z", exp_v.normal_z, out_data.normal_z);
          compare_field("last_vertex", exp_v.last_vertex, out_data.last_vertex);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    hng_pkg::in_item_t  item;
    hng_pkg::out_item_t flat;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = hng_pkg::CFG_GRID_WIDTH;
    cfg_data = '0;
    mismatches = 0;
    vertices_seen = 0;
    beats_sent = 0;
    idle_cycles = 0;
    reg_width = 2;
    reg_height = 2;
    reg_cell = 256;
    reg_border = 0;
    foreach (upper_row[i]) begin
      upper_row[i] = '0;
      middle_row[i] = '0;
    end
    restart_frame();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      item.opcode = directed_rows[i].op;
      item.height_sample = directed_rows[i].height;
      flat = '{vertex_col: directed_rows[i].col, vertex_row: directed_rows[i].row,
               vertex_height: 16'sd0, normal_x: 16'sd0, normal_y: 15'd32767,
               normal_z: 16'sd0, last_vertex: directed_rows[i].last};
      send_beat(item, 1, directed_rows[i].fixed, flat);
    end
    wait_drained();

    set_grid(3, 3, 256, 0);
    run_random(150);
    set_grid(4, 2, 1, 1);
    run_random(150);
    set_grid(0, 1, 65535, 0);
    run_random(100);
    set_grid(5, 4, 0, 2);
    run_random(150);
    set_grid(256, 2, 700, 0);
    run_random(600);
    set_grid(7, 4096, 50, 15);
    run_random(200);
    set_grid(511, 8191, 128, 0);
    run_random(100);
    set_grid(2, 2, 256, 0);
    run_random(50);

    if (mismatches == 0 && pending_vertices.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
design/hng_pkg.sv
design/hng_div.sv
design/hng_isqrt.sv
design/hng_ctrl.sv
design/hng_datapath.sv
design/heightmap_normal_generator.sv
sim/testbench.sv
